/* hw/rtl/odo_pkg.sv */
// ----------------------------------------------------------------------------
// odo_pkg
// Shared constants, datapath operation codes, the sequencer program and the
// CORDIC arctangent table for the differential drive odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

  // CORDIC configuration
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int ANGLE_DROP   = 32 - ANGLE_BITS;
  localparam int ZW           = ANGLE_BITS + 2;

  localparam logic [32:0] ANGLE_RND = 33'(64'd1 << (ANGLE_DROP - 1));
  localparam logic signed [ZW-1:0] Z_FULL    = ZW'(64'd1 << ANGLE_BITS);
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'd1 << (ANGLE_BITS - 1));
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'd1 << (ANGLE_BITS - 2));

  // Shared restoring divider: 49-bit dividend, 48-bit divisor
  localparam int DIV_BITS = 49;
  localparam int DVS_W    = 48;
  localparam int CNT_W    = 6;

  // Fixed-point constants
  localparam logic [29:0]        INV_2PI_Q32 = 30'd683565276;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
  localparam logic [15:0]        RPM_SCALE   = 16'd60000;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_TICKS_PER_CM  = 2'd0;
  localparam logic [1:0] CFG_WHEEL_BASE_CM = 2'd1;
  localparam logic [1:0] CFG_TICKS_PER_REV = 2'd2;

  localparam logic [15:0] RST_TICKS_PER_CM  = 16'd256;
  localparam logic [15:0] RST_WHEEL_BASE_CM = 16'd9216;
  localparam logic [15:0] RST_TICKS_PER_REV = 16'd1060;

  // Datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE        = 5'd0;
  localparam op_t OP_LOAD        = 5'd1;
  localparam op_t OP_DELTA       = 5'd2;
  localparam op_t OP_MUL_TW      = 5'd3;
  localparam op_t OP_MUL_TH      = 5'd4;
  localparam op_t OP_MUL_TT      = 5'd5;
  localparam op_t OP_MUL_RPM_L   = 5'd6;
  localparam op_t OP_MUL_RPM_R   = 5'd7;
  localparam op_t OP_MUL_X       = 5'd8;
  localparam op_t OP_MUL_Y       = 5'd9;
  localparam op_t OP_DVS_PROD    = 5'd10;
  localparam op_t OP_DVS_TPC     = 5'd11;
  localparam op_t OP_DIV_PROD    = 5'd12;
  localparam op_t OP_DIV_DL      = 5'd13;
  localparam op_t OP_DIV_DR      = 5'd14;
  localparam op_t OP_DIV_STEP    = 5'd15;
  localparam op_t OP_SET_DTH     = 5'd16;
  localparam op_t OP_SET_LQ      = 5'd17;
  localparam op_t OP_SET_RQ      = 5'd18;
  localparam op_t OP_SET_RPML    = 5'd19;
  localparam op_t OP_SET_RPMR    = 5'd20;
  localparam op_t OP_CORDIC_INIT = 5'd21;
  localparam op_t OP_CORDIC_STEP = 5'd22;
  localparam op_t OP_CORDIC_END  = 5'd23;
  localparam op_t OP_ACC_X       = 5'd24;
  localparam op_t OP_ACC_Y       = 5'd25;
  localparam op_t OP_OUT         = 5'd26;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] idx;
  } odo_cmd_t;

  localparam logic [4:0] PROG_LAST = 5'd24;

  // Sequencer program, one operation per step
  function automatic op_t prog_op(input logic [4:0] pc);
    op_t op;
    unique case (pc)
      5'd0:    op = OP_DELTA;
      5'd1:    op = OP_MUL_TW;
      5'd2:    op = OP_DVS_PROD;
      5'd3:    op = OP_MUL_TH;
      5'd4:    op = OP_DIV_PROD;
      5'd5:    op = OP_SET_DTH;
      5'd6:    op = OP_DVS_TPC;
      5'd7:    op = OP_DIV_DL;
      5'd8:    op = OP_SET_LQ;
      5'd9:    op = OP_DIV_DR;
      5'd10:   op = OP_SET_RQ;
      5'd11:   op = OP_MUL_TT;
      5'd12:   op = OP_DVS_PROD;
      5'd13:   op = OP_MUL_RPM_L;
      5'd14:   op = OP_DIV_PROD;
      5'd15:   op = OP_SET_RPML;
      5'd16:   op = OP_MUL_RPM_R;
      5'd17:   op = OP_DIV_PROD;
      5'd18:   op = OP_SET_RPMR;
      5'd19:   op = OP_CORDIC_INIT;
      5'd20:   op = OP_CORDIC_END;
      5'd21:   op = OP_MUL_X;
      5'd22:   op = OP_ACC_X;
      5'd23:   op = OP_MUL_Y;
      5'd24:   op = OP_ACC_Y;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_q32(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/odo_ctrl.sv */
// ----------------------------------------------------------------------------
// odo_ctrl
// Controller: handshakes, program and loop counters. One datapath op per
// cycle unless idle or stalled on the result beat, which it holds until taken.
// ----------------------------------------------------------------------------
module odo_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output odo_pkg::odo_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_LOOP = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [4:0]                 pc_r, pc_nxt;
  logic [odo_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_last;
  odo_pkg::op_t               loop_op_r, loop_op_nxt, cur_op;
  logic                       out_valid_r, out_valid_nxt;

  assign cur_op   = odo_pkg::prog_op(pc_r);
  assign cnt_last = (loop_op_r == odo_pkg::OP_DIV_STEP) ?
                    odo_pkg::CNT_W'(odo_pkg::DIV_BITS - 1) :
                    odo_pkg::CNT_W'(odo_pkg::CORDIC_STEPS - 1);

  // Sequence the program
  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    cnt_nxt     = cnt_r;
    loop_op_nxt = loop_op_r;
    cmd.op      = odo_pkg::OP_NONE;
    cmd.idx     = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = odo_pkg::OP_LOAD;
          state_nxt = S_RUN;
          pc_nxt    = 5'd0;
        end
      end
      S_RUN: begin
        cmd.op = cur_op;
        if (cur_op == odo_pkg::OP_DIV_PROD || cur_op == odo_pkg::OP_DIV_DL ||
            cur_op == odo_pkg::OP_DIV_DR) begin
          loop_op_nxt = odo_pkg::OP_DIV_STEP;
          cnt_nxt     = '0;
          state_nxt   = S_LOOP;
        end else if (cur_op == odo_pkg::OP_CORDIC_INIT) begin
          loop_op_nxt = odo_pkg::OP_CORDIC_STEP;
          cnt_nxt     = '0;
          state_nxt   = S_LOOP;
        end else if (pc_r == odo_pkg::PROG_LAST) begin
          state_nxt = S_FIN;
        end else begin
          pc_nxt = pc_r + 5'd1;
        end
      end
      S_LOOP: begin
        cmd.op = loop_op_r;
        if (cnt_r == cnt_last) begin
          state_nxt = S_RUN;
          pc_nxt    = pc_r + 5'd1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op    = odo_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Raise valid on a new result, drop it once the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == odo_pkg::OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      cnt_r       <= '0;
      loop_op_r   <= odo_pkg::OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      loop_op_r   <= loop_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/odo_dp.sv */
// ----------------------------------------------------------------------------
// odo_dp
// Datapath: odometry state, configuration registers, one shared multiplier,
// a radix-2 restoring divider and an iterative CORDIC rotator.
// ----------------------------------------------------------------------------
module odo_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  odo_pkg::odo_cmd_t        cmd,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic signed [15:0]       in_left_count,
  input  logic signed [15:0]       in_right_count,
  input  logic [31:0]              in_now_ms,
  input  logic                     in_imu_used,
  input  logic [15:0]              in_imu_yaw,
  output logic signed [31:0]       out_x_pos,
  output logic signed [31:0]       out_y_pos,
  output logic [15:0]              out_heading,
  output logic signed [15:0]       out_rpm_left,
  output logic signed [15:0]       out_rpm_right
);

  localparam int ZW  = odo_pkg::ZW;
  localparam int DB  = odo_pkg::DIV_BITS;
  localparam int DW  = odo_pkg::DVS_W;

  // Configuration and odometry state
  logic [15:0]        tpc_r, wb_r, tpr_r;
  logic [15:0]        prev_left_r, prev_right_r, theta_r;
  logic [31:0]        prev_time_r;
  logic signed [31:0] x_r, y_r;

  // Latched input beat
  logic [15:0] lc_r, rc_r, yaw_r;
  logic [31:0] now_r;
  logic        use_imu_r;

  // Working registers
  logic signed [15:0] dl_r, dr_r;
  logic [31:0]        dt_r;
  logic [15:0]        ang_r;
  logic signed [66:0] prod_r;
  logic [DW-1:0]      dvs_r;
  logic [DB-1:0]      quo_r;
  logic [DW-1:0]      rem_r;
  logic               div_neg_r;
  logic signed [33:0] lq_r, rq_r;
  logic [15:0]        rpm_l_r, rpm_r_r;
  logic signed [32:0] xc_r, yc_r, sn_r, cs_r;
  logic signed [ZW-1:0] zc_r;
  logic               cneg_r;

  // Effective registers: zero reads as one
  logic [15:0] tpc_e, wb_e, tpr_e;
  assign tpc_e = (tpc_r == 16'd0) ? 16'd1 : tpc_r;
  assign wb_e  = (wb_r  == 16'd0) ? 16'd1 : wb_r;
  assign tpr_e = (tpr_r == 16'd0) ? 16'd1 : tpr_r;

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_p;
  logic signed [16:0] ddiff;
  logic signed [33:0] wsum;
  logic               is_mul;

  assign ddiff = {dl_r[15], dl_r} - {dr_r[15], dr_r};
  assign wsum  = lq_r + rq_r;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    unique case (cmd.op)
      odo_pkg::OP_MUL_TW: begin
        mul_a = $signed({18'd0, tpc_e});
        mul_b = $signed({17'd0, wb_e});
      end
      odo_pkg::OP_MUL_TH: begin
        mul_a = {{17{ddiff[16]}}, ddiff};
        mul_b = $signed({3'd0, odo_pkg::INV_2PI_Q32});
      end
      odo_pkg::OP_MUL_TT: begin
        mul_a = $signed({18'd0, tpr_e});
        mul_b = $signed({1'b0, dt_r});
      end
      odo_pkg::OP_MUL_RPM_L: begin
        mul_a = {{18{dl_r[15]}}, dl_r};
        mul_b = $signed({17'd0, odo_pkg::RPM_SCALE});
      end
      odo_pkg::OP_MUL_RPM_R: begin
        mul_a = {{18{dr_r[15]}}, dr_r};
        mul_b = $signed({17'd0, odo_pkg::RPM_SCALE});
      end
      odo_pkg::OP_MUL_X: begin
        mul_a = wsum;
        mul_b = sn_r;
      end
      odo_pkg::OP_MUL_Y: begin
        mul_a = wsum;
        mul_b = cs_r;
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divider start values, rounding half the divisor into the dividend
  logic [66:0]   prod_mag;
  logic [16:0]   dl_mag, dr_mag;
  logic [DB-1:0] half_dvs, num_prod, num_dl, num_dr;

  assign prod_mag = prod_r[66] ? 67'(-prod_r) : 67'(prod_r);
  assign dl_mag   = dl_r[15] ? 17'(-{dl_r[15], dl_r}) : {1'b0, dl_r};
  assign dr_mag   = dr_r[15] ? 17'(-{dr_r[15], dr_r}) : {1'b0, dr_r};
  assign half_dvs = {2'b00, dvs_r[DW-1:1]};
  assign num_prod = {1'b0, prod_mag[DW-1:0]} + half_dvs;
  assign num_dl   = {16'd0, dl_mag, 16'd0} + half_dvs;
  assign num_dr   = {16'd0, dr_mag, 16'd0} + half_dvs;

  // Divider step
  logic [DB-1:0] div_r2;
  logic          div_ge;
  assign div_r2 = {rem_r, quo_r[DB-1]};
  assign div_ge = (div_r2 >= {1'b0, dvs_r});

  // Quotient with sign applied
  logic [15:0]        dth;
  logic signed [33:0] qsx;
  assign dth = div_neg_r ? 16'(-quo_r[15:0]) : quo_r[15:0];
  assign qsx = div_neg_r ? -$signed({2'b00, quo_r[31:0]}) : $signed({2'b00, quo_r[31:0]});

  // Saturate a rounded rpm quotient
  function automatic logic [15:0] rpm_sat(input logic [DB-1:0] q, input logic neg,
                                          input logic dt_zero,
                                          input logic signed [15:0] d);
    logic [15:0] r;
    if (dt_zero) begin
      if (d > 16'sd0)      r = 16'h7FFF;
      else if (d < 16'sd0) r = 16'h8000;
      else                 r = 16'h0000;
    end else if (neg) begin
      r = (q > DB'(32768)) ? 16'h8000 : 16'(-q[15:0]);
    end else begin
      r = (q > DB'(32767)) ? 16'h7FFF : q[15:0];
    end
    return r;
  endfunction

  logic dt_zero;
  assign dt_zero = (dt_r == 32'd0);

  // CORDIC start: round angle to working resolution and fold to +-1/4 turn
  logic [32:0]          ang_t;
  logic signed [ZW-1:0] z0a, z0;
  logic                 z0neg;
  assign ang_t = {1'b0, ang_r, 16'd0} + odo_pkg::ANGLE_RND;

  always_comb begin
    z0a   = $signed({2'b00, ang_t[31:odo_pkg::ANGLE_DROP]});
    z0neg = 1'b0;
    if (z0a >= odo_pkg::Z_HALF) begin
      z0a = z0a - odo_pkg::Z_FULL;
    end
    z0 = z0a;
    if (z0a >= odo_pkg::Z_QUARTER) begin
      z0    = z0a - odo_pkg::Z_HALF;
      z0neg = 1'b1;
    end else if (z0a < -odo_pkg::Z_QUARTER) begin
      z0    = z0a + odo_pkg::Z_HALF;
      z0neg = 1'b1;
    end
  end

  // CORDIC rotation step
  logic [4:0]           ci;
  logic [32:0]          at_t;
  logic signed [ZW-1:0] az;
  logic signed [32:0]   xs, ys, xf, yf;
  assign ci   = cmd.idx[4:0];
  assign at_t = {1'b0, odo_pkg::atan_q32(ci)} + odo_pkg::ANGLE_RND;
  assign az   = $signed({2'b00, at_t[31:odo_pkg::ANGLE_DROP]});
  assign xs   = xc_r >>> ci;
  assign ys   = yc_r >>> ci;
  assign xf   = cneg_r ? -xc_r : xc_r;
  assign yf   = cneg_r ? -yc_r : yc_r;

  function automatic logic signed [32:0] clamp_q30(input logic signed [32:0] v);
    logic signed [32:0] r;
    if (v > odo_pkg::ONE_Q30)       r = odo_pkg::ONE_Q30;
    else if (v < -odo_pkg::ONE_Q30) r = -odo_pkg::ONE_Q30;
    else                            r = v;
    return r;
  endfunction

  // Position step: round product / 2^31, add with int32 saturation
  logic [66:0]        prod_rnd;
  logic signed [33:0] pstep, acc_in, acc_sum;
  logic signed [31:0] acc_sat;
  assign prod_rnd = prod_mag + 67'(64'd1 << 30);
  assign pstep    = prod_r[66] ? -$signed({1'b0, prod_rnd[63:31]}) :
                                 $signed({1'b0, prod_rnd[63:31]});
  assign acc_in   = (cmd.op == odo_pkg::OP_ACC_X) ? 34'(x_r) : 34'(y_r);
  assign acc_sum  = acc_in + pstep;

  always_comb begin
    if (acc_sum > 34'sd2147483647)       acc_sat = 32'sh7FFFFFFF;
    else if (acc_sum < -34'sd2147483648) acc_sat = 32'sh80000000;
    else                                 acc_sat = acc_sum[31:0];
  end

  // Configuration and odometry state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpc_r        <= odo_pkg::RST_TICKS_PER_CM;
      wb_r         <= odo_pkg::RST_WHEEL_BASE_CM;
      tpr_r        <= odo_pkg::RST_TICKS_PER_REV;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      prev_time_r  <= '0;
      theta_r      <= '0;
      x_r          <= '0;
      y_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          odo_pkg::CFG_TICKS_PER_CM:  tpc_r <= cfg_data;
          odo_pkg::CFG_WHEEL_BASE_CM: wb_r  <= cfg_data;
          odo_pkg::CFG_TICKS_PER_REV: tpr_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == odo_pkg::OP_DELTA) begin
        prev_left_r  <= lc_r;
        prev_right_r <= rc_r;
        prev_time_r  <= now_r;
      end
      if (cmd.op == odo_pkg::OP_SET_DTH) theta_r <= theta_r + dth;
      if (cmd.op == odo_pkg::OP_ACC_X)   x_r <= acc_sat;
      if (cmd.op == odo_pkg::OP_ACC_Y)   y_r <= acc_sat;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (is_mul) prod_r <= mul_p;
    unique case (cmd.op)
      odo_pkg::OP_LOAD: begin
        lc_r      <= in_left_count;
        rc_r      <= in_right_count;
        now_r     <= in_now_ms;
        use_imu_r <= in_imu_used;
        yaw_r     <= in_imu_yaw;
      end
      odo_pkg::OP_DELTA: begin
        dl_r  <= $signed(lc_r - prev_left_r);
        dr_r  <= $signed(rc_r - prev_right_r);
        dt_r  <= now_r - prev_time_r;
        ang_r <= use_imu_r ? yaw_r : theta_r;
      end
      odo_pkg::OP_DVS_PROD: dvs_r <= prod_r[DW-1:0];
      odo_pkg::OP_DVS_TPC:  dvs_r <= {32'd0, tpc_e};
      odo_pkg::OP_DIV_PROD: begin
        quo_r     <= num_prod;
        rem_r     <= '0;
        div_neg_r <= prod_r[66];
      end
      odo_pkg::OP_DIV_DL: begin
        quo_r     <= num_dl;
        rem_r     <= '0;
        div_neg_r <= dl_r[15];
      end
      odo_pkg::OP_DIV_DR: begin
        quo_r     <= num_dr;
        rem_r     <= '0;
        div_neg_r <= dr_r[15];
      end
      odo_pkg::OP_DIV_STEP: begin
        rem_r <= div_ge ? DW'(div_r2 - {1'b0, dvs_r}) : div_r2[DW-1:0];
        quo_r <= {quo_r[DB-2:0], div_ge};
      end
      odo_pkg::OP_SET_LQ:   lq_r    <= qsx;
      odo_pkg::OP_SET_RQ:   rq_r    <= qsx;
      odo_pkg::OP_SET_RPML: rpm_l_r <= rpm_sat(quo_r, div_neg_r, dt_zero, dl_r);
      odo_pkg::OP_SET_RPMR: rpm_r_r <= rpm_sat(quo_r, div_neg_r, dt_zero, dr_r);
      odo_pkg::OP_CORDIC_INIT: begin
        xc_r   <= odo_pkg::CORDIC_GAIN;
        yc_r   <= '0;
        zc_r   <= z0;
        cneg_r <= z0neg;
      end
      odo_pkg::OP_CORDIC_STEP: begin
        if (!zc_r[ZW-1]) begin
          xc_r <= xc_r - ys;
          yc_r <= yc_r + xs;
          zc_r <= zc_r - az;
        end else begin
          xc_r <= xc_r + ys;
          yc_r <= yc_r - xs;
          zc_r <= zc_r + az;
        end
      end
      odo_pkg::OP_CORDIC_END: begin
        sn_r <= clamp_q30(yf);
        cs_r <= clamp_q30(xf);
      end
      odo_pkg::OP_OUT: begin
        out_x_pos     <= x_r;
        out_y_pos     <= y_r;
        out_heading   <= theta_r;
        out_rpm_left  <= $signed(rpm_l_r);
        out_rpm_right <= $signed(rpm_r_r);
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/differential_drive_odometry_top.sv */
// Each input beat is loaded, run through 25 program steps, including five
// 49-step divisions on the shared radix-2 divider and 16 CORDIC rotations,
// then published; no new input beat is taken before the current one is published.
// Reset: synchronous, active low; clears position, heading, previous counters
// and timestamp and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Dead-reckoning odometry for a differential drive: wheel travel, heading,
// CORDIC-rotated position update and wheel rpm per encoder sample.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_left_count,
  input  logic signed [15:0] in_right_count,
  input  logic [31:0]        in_now_ms,
  input  logic               in_imu_used,
  input  logic [15:0]        in_imu_yaw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x_pos,
  output logic signed [31:0] out_y_pos,
  output logic [15:0]        out_heading,
  output logic signed [15:0] out_rpm_left,
  output logic signed [15:0] out_rpm_right,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  odo_pkg::odo_cmd_t cmd;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  odo_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_left_count  (in_left_count),
    .in_right_count (in_right_count),
    .in_now_ms      (in_now_ms),
    .in_imu_used    (in_imu_used),
    .in_imu_yaw     (in_imu_yaw),
    .out_x_pos      (out_x_pos),
    .out_y_pos      (out_y_pos),
    .out_heading    (out_heading),
    .out_rpm_left   (out_rpm_left),
    .out_rpm_right  (out_rpm_right)
  );

endmodule

/* verif/odo_track_check.sv */
// ----------------------------------------------------------------------------
// odo_track_check
// Watches the input, result and register channels of the odometry block,
// tracks pose, heading and wheel rpm for every accepted input beat and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module odo_track_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_left_count,
  input  logic signed [15:0] in_right_count,
  input  logic [31:0]        in_now_ms,
  input  logic               in_imu_used,
  input  logic [15:0]        in_imu_yaw,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x_pos,
  input  logic signed [31:0] out_y_pos,
  input  logic [15:0]        out_heading,
  input  logic signed [15:0] out_rpm_left,
  input  logic signed [15:0] out_rpm_right,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 pending,
  output int                 fail_count
);

  typedef struct {
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [15:0]        heading;
    logic signed [15:0] rpm_left;
    logic signed [15:0] rpm_right;
  } pose_t;

  // arctangent of 2^-i in 2^-32 turn
  localparam longint ARCTAN_TURN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  localparam longint GAIN_Q30 = 652032874;
  localparam longint UNIT_Q30 = 1073741824;
  localparam longint TURN_INV = 683565276;

  logic [15:0] tpc_reg, wb_reg, tpr_reg;
  logic [15:0] last_left, last_right;
  logic [31:0] last_ms;
  logic [15:0] theta;
  longint      x_track, y_track;
  pose_t       pose_queue [$];
  int          beat_num;

  assign pending = pose_queue.size();

  // divide rounding to nearest, ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // fold into +-1/4 turn, then rotate with the fixed gain preloaded
  task automatic rotate(input logic [15:0] ang, output longint sn, output longint cs);
    longint z, x, y, a, xs, ys;
    bit     flip;
    z    = longint'(ang);
    x    = GAIN_Q30;
    y    = 0;
    flip = 0;
    if (z >= 32768) z -= 65536;
    if (z >= 16384) begin
      z -= 32768;
      flip = 1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      a  = (ARCTAN_TURN[i] + 32768) >>> 16;
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= a;
      end else begin
        x += ys; y -= xs; z += a;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sn = clip(y, -UNIT_Q30, UNIT_Q30);
    cs = clip(x, -UNIT_Q30, UNIT_Q30);
  endtask

  function automatic logic [15:0] wheel_rpm(longint d, logic [31:0] dt);
    longint tpr;
    tpr = (tpr_reg == 0) ? 1 : longint'(tpr_reg);
    if (dt == 0) return (d > 0) ? 16'sd32767 : ((d < 0) ? -16'sd32768 : 16'sd0);
    return 16'(clip(round_div(d * 60000, tpr * longint'(dt)), -32768, 32767));
  endfunction

  // advance the tracked pose by one encoder sample
  task automatic advance_pose(input logic [15:0] lc, input logic [15:0] rc,
                              input logic [31:0] now, input logic use_imu,
                              input logic [15:0] yaw, output pose_t res);
    longint dl, dr, tpc, wb, lq, rq, dth, sn, cs;
    logic [15:0] old_theta;
    logic [31:0] dt;
    dl  = longint'($signed(16'(lc - last_left)));
    dr  = longint'($signed(16'(rc - last_right)));
    tpc = (tpc_reg == 0) ? 1 : longint'(tpc_reg);
    wb  = (wb_reg == 0) ? 1 : longint'(wb_reg);
    lq  = round_div(dl * 65536, tpc);
    rq  = round_div(dr * 65536, tpc);
    dth = round_div((dl - dr) * TURN_INV, tpc * wb);
    old_theta  = theta;
    dt         = now - last_ms;
    last_left  = lc;
    last_right = rc;
    last_ms    = now;
    theta      = 16'(theta + 16'(dth));
    rotate(use_imu ? yaw : old_theta, sn, cs);
    x_track = clip(x_track + round_div((lq + rq) * sn, 64'sd1 << 31),
                   -64'sd2147483648, 64'sd2147483647);
    y_track = clip(y_track + round_div((lq + rq) * cs, 64'sd1 << 31),
                   -64'sd2147483648, 64'sd2147483647);
    res.x_pos     = 32'(x_track);
    res.y_pos     = 32'(y_track);
    res.heading   = theta;
    res.rpm_left  = wheel_rpm(dl, dt);
    res.rpm_right = wheel_rpm(dr, dt);
  endtask

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch beat %0d %s: got %0d want %0d", beat_num, field, got, want);
    fail_count++;
  endtask

  // track registers, predict on input beats, compare on result beats
  always @(posedge clk) begin
    pose_t p;
    pose_t e;
    if (!rst_n) begin
      tpc_reg    <= odo_pkg::RST_TICKS_PER_CM;
      wb_reg     <= odo_pkg::RST_WHEEL_BASE_CM;
      tpr_reg    <= odo_pkg::RST_TICKS_PER_REV;
      last_left  = '0;
      last_right = '0;
      last_ms    = '0;
      theta      = '0;
      x_track    = 0;
      y_track    = 0;
      beat_num   = 0;
      fail_count = 0;
      pose_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          odo_pkg::CFG_TICKS_PER_CM:  tpc_reg <= cfg_data;
          odo_pkg::CFG_WHEEL_BASE_CM: wb_reg  <= cfg_data;
          odo_pkg::CFG_TICKS_PER_REV: tpr_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_pose(in_left_count, in_right_count, in_now_ms, in_imu_used,
                     in_imu_yaw, p);
        pose_queue.push_back(p);
      end
      if (out_valid && !out_stall) begin
        if (pose_queue.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          e = pose_queue.pop_front();
          if (out_x_pos !== e.x_pos) report("x_pos", out_x_pos, e.x_pos);
          if (out_y_pos !== e.y_pos) report("y_pos", out_y_pos, e.y_pos);
          if (out_heading !== e.heading) report("heading", out_heading, e.heading);
          if (out_rpm_left !== e.rpm_left) report("rpm_left", out_rpm_left, e.rpm_left);
          if (out_rpm_right !== e.rpm_right)
            report("rpm_right", out_rpm_right, e.rpm_right);
        end
        beat_num++;
      end
    end
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives encoder samples and register writes into the odometry block: a
// directed opening, then random encoder tracks over several register settings,
// with bursty input and patterned result stalls. Checking lives in
// odo_track_check.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  LATENCY   = 300;
  localparam longint LIMIT  = 4000000;

  // index that maps to no register
  localparam logic [1:0] CFG_NO_REG = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_left_count;
  logic signed [15:0] in_right_count;
  logic [31:0]        in_now_ms;
  logic               in_imu_used;
  logic [15:0]        in_imu_yaw;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_x_pos;
  logic signed [31:0] out_y_pos;
  logic [15:0]        out_heading;
  logic signed [15:0] out_rpm_left;
  logic signed [15:0] out_rpm_right;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 pending;
  int                 fail_count;
  longint             cycles = 0;
  logic [15:0]        enc_left, enc_right;
  logic [31:0]        stamp;

  differential_drive_odometry_top dut (.*);

  odo_track_check u_check (.*);

  initial clk = 0;
  always #2 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result stall pattern: stretches of none, random, solid and sparse stalls
  always @(posedge clk) begin
    int mode;
    int left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode = 0;
      left = 100;
    end else begin
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 250);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= 1'b1;
        default: out_stall <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // hold one input beat until accepted
  task automatic send(input logic [15:0] l, input logic [15:0] r, input logic [31:0] t,
                      input logic imu, input logic [15:0] yaw);
    in_valid       <= 1'b1;
    in_left_count  <= l;
    in_right_count <= r;
    in_now_ms      <= t;
    in_imu_used    <= imu;
    in_imu_yaw     <= yaw;
    enc_left  = l;
    enc_right = r;
    stamp     = t;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
  endtask

  task automatic pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drain results and let the block settle before touching registers
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] tpc, input logic [15:0] wb,
                           input logic [15:0] tpr);
    write_reg(odo_pkg::CFG_TICKS_PER_CM, tpc);
    write_reg(odo_pkg::CFG_WHEEL_BASE_CM, wb);
    write_reg(odo_pkg::CFG_TICKS_PER_REV, tpr);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random encoder track: mostly plausible motion, some wild jumps
  task automatic random_phase(input int count);
    int burst;
    logic [15:0] l, r;
    logic [31:0] t;
    burst = $urandom_range(1, 12);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          l = 16'($urandom);
          r = 16'($urandom);
        end
        1, 2: begin
          l = enc_left + 16'($urandom_range(0, 4000)) - 16'd2000;
          r = enc_right + 16'($urandom_range(0, 4000)) - 16'd2000;
        end
        default: begin
          l = enc_left + 16'($urandom_range(0, 200)) - 16'd100;
          r = enc_right + 16'($urandom_range(0, 200)) - 16'd100;
        end
      endcase
      case ($urandom_range(0, 9))
        0: t = $urandom;
        1: t = stamp;
        default: t = stamp + $urandom_range(1, 200);
      endcase
      send(l, r, t, 1'($urandom_range(0, 1)), 16'($urandom));
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 400));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_left_count  = '0;
    in_right_count = '0;
    in_now_ms      = '0;
    in_imu_used    = 1'b0;
    in_imu_yaw     = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    enc_left       = '0;
    enc_right      = '0;
    stamp          = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: zero elapsed time, extremes, yaw quadrants, time wrap
    send(16'd0, 16'd0, 32'd0, 1'b0, 16'd0);
    send(16'd100, 16'd50, 32'd0, 1'b0, 16'd0);
    send(16'd0, -16'sd200, 32'd0, 1'b0, 16'd0);
    send(16'sd32767, -16'sd32768, 32'd10, 1'b0, 16'd0);
    send(-16'sd32768, 16'sd32767, 32'd20, 1'b1, 16'd0);
    send(-16'sd30000, 16'sd30000, 32'd25, 1'b1, 16'd16384);
    send(-16'sd20000, -16'sd25000, 32'd30, 1'b1, 16'd32768);
    send(-16'sd10000, -16'sd20000, 32'd40, 1'b1, 16'd49152);
    send(16'd0, 16'd0, 32'd41, 1'b1, 16'd65535);
    send(16'd500, 16'd700, 32'hFFFF_FFF0, 1'b1, 16'd8192);
    send(16'd900, 16'd800, 32'd5, 1'b0, 16'd0);
    send(16'd900, 16'd800, 32'hFFFF_FFFF, 1'b0, 16'hFFFF);

    // one tick per cm: drive both positions into saturation and back
    drain();
    write_all(16'd1, 16'd1, 16'd1);
    send(enc_left + 16'd32767, enc_right + 16'd32767, stamp + 1, 1'b1, 16'd16384);
    send(enc_left + 16'd32767, enc_right + 16'd32767, stamp + 1, 1'b1, 16'd0);
    send(enc_left + 16'd32767, enc_right + 16'd32767, stamp + 1, 1'b1, 16'd16384);
    send(enc_left + 16'd32767, enc_right + 16'd32767, stamp + 1, 1'b1, 16'd0);
    send(enc_left - 16'd32768, enc_right - 16'd32768, stamp + 1, 1'b1, 16'd0);
    send(enc_left + 16'd32767, enc_right + 16'd32767, stamp + 1, 1'b1, 16'd49152);
    send(enc_left + 16'd32767, enc_right + 16'd32767, stamp + 1, 1'b1, 16'd32768);
    send(enc_left + 16'd32767, enc_right + 16'd32767, stamp + 1, 1'b1, 16'd49152);
    send(enc_left + 16'd32767, enc_right + 16'd32767, stamp + 1, 1'b1, 16'd32768);

    // zero registers act as one; unknown index is dropped
    drain();
    write_all(16'd0, 16'd0, 16'd0);
    write_reg(CFG_NO_REG, 16'hFFFF);
    cfg_valid <= 1'b0;
    send(enc_left + 16'd7, enc_right - 16'd9, stamp + 3, 1'b0, 16'd0);
    send(enc_left - 16'd3, enc_right + 16'd1, stamp, 1'b0, 16'd0);

    // random tracks across register settings, extremes included
    drain();
    write_all(16'd65535, 16'd65535, 16'd65535);
    random_phase(100);
    drain();
    write_all(odo_pkg::RST_TICKS_PER_CM, odo_pkg::RST_WHEEL_BASE_CM,
              odo_pkg::RST_TICKS_PER_REV);
    random_phase(140);
    drain();
    write_all(16'd1, 16'd1, 16'd1);
    random_phase(80);
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      write_all(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)));
      random_phase(110);
    end

    // drain and verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/odo_pkg.sv
hw/rtl/odo_ctrl.sv
hw/rtl/odo_dp.sv
hw/rtl/differential_drive_odometry_top.sv
verif/odo_track_check.sv
verif/tb_top.sv
